@@ src/uart_register_fifo_controller_top_defines.svh @@
// Assertion macros for the UART register and FIFO block.
`ifndef UART_REGISTER_FIFO_CONTROLLER_TOP_DEFINES_SVH
`define UART_REGISTER_FIFO_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define URFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urfc check failed");

// Next-cycle implication, checked outside reset.
`define URFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urfc check failed");

`endif

@@ src/urfc_pkg.sv @@
// Shared types, constants and helpers for the UART register and FIFO block.
package urfc_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W      = (FILL_W > 3) ? FILL_W : 3;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_LINE_RX = 2'd2;
    localparam logic [1:0] CMD_TX_RDY  = 2'd3;

    localparam logic [2:0] REG_TXDATA = 3'd0;
    localparam logic [2:0] REG_RXDATA = 3'd1;
    localparam logic [2:0] REG_TXCTRL = 3'd2;
    localparam logic [2:0] REG_RXCTRL = 3'd3;
    localparam logic [2:0] REG_IE     = 3'd4;
    localparam logic [2:0] REG_IP     = 3'd5;
    localparam logic [2:0] REG_DIV    = 3'd6;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef struct packed {
        logic       tx_we;
        ptr_t       tx_waddr;
        logic [7:0] tx_wdata;
        logic       tx_re;
        ptr_t       tx_raddr;
        logic       rx_we;
        ptr_t       rx_waddr;
        logic [7:0] rx_wdata;
        logic       rx_re;
        ptr_t       rx_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] rd_word;
        logic        rx_sel;
        logic        send_valid;
        logic        dropped;
        logic        tx_irq;
        logic        rx_irq;
        logic [15:0] divisor;
        logic        two_stop;
        logic        rx_on;
        logic        tx_on;
    } result_t;

    typedef struct packed {
        fill_t tx_fill;
        fill_t rx_fill;
    } fifo_status_t;

    function automatic ptr_t wrap_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic ptr_t wrap_add(input ptr_t head, input fill_t fill);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(head) + (FILL_W+1)'(fill);
        if (s >= (FILL_W+1)'(FIFO_DEPTH))
        begin
            s = s - (FILL_W+1)'(FIFO_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [31:0] be_mask(input logic [3:0] be);
        return {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    endfunction

endpackage

@@ src/uart_register_fifo_controller_top.sv @@
// Top level of the UART register block with transmit and receive byte FIFOs.
//
// Every bus access or line event is one item, and the block takes one item per
// clock unless a result waiting for out_ready holds it. Register and pointer
// updates happen in the cycle an item is accepted; the two FIFO byte RAMs are
// read in that same cycle and their registered read data joins the result in
// the following stage, as it moves from s1_res_reg into the output register.
// The memory stage and the output register together let one more item in while
// a result waits for out_ready. Both FIFOs hold FIFO_DEPTH bytes; their contents
// are not cleared at reset, only the pointers and fill levels are.
`include "uart_register_fifo_controller_top_defines.svh"

module uart_register_fifo_controller_top
    import urfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_word,
    input  logic [3:0]  byte_enables,
    input  logic [7:0]  line_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_word,
    output logic [7:0]  send_byte,
    output logic        send_valid,
    output logic        dropped,
    output logic        tx_irq,
    output logic        rx_irq,
    output logic [15:0] baud_divisor,
    output logic        two_stop_bits,
    output logic        receiver_on,
    output logic        transmitter_on
);

    logic         accept;
    logic         s1_advance;
    mem_req_t     req;
    result_t      res;
    fifo_status_t status;
    logic [7:0]   tx_rdata, rx_rdata;

    logic         s1_valid_reg;
    result_t      s1_res_reg;
    logic         out_valid_reg;
    result_t      out_res_reg;
    logic [31:0]  out_word_reg;
    logic [7:0]   out_byte_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    urfc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .reg_index    (reg_index),
        .write_word   (write_word),
        .byte_enables (byte_enables),
        .line_byte    (line_byte),
        .req          (req),
        .res          (res),
        .status       (status)
    );

    urfc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(8)) u_tx_ram (
        .clk   (clk),
        .we    (req.tx_we),
        .waddr (req.tx_waddr),
        .wdata (req.tx_wdata),
        .re    (req.tx_re),
        .raddr (req.tx_raddr),
        .rdata (tx_rdata)
    );

    urfc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(8)) u_rx_ram (
        .clk   (clk),
        .we    (req.rx_we),
        .waddr (req.rx_waddr),
        .wdata (req.rx_wdata),
        .re    (req.rx_re),
        .raddr (req.rx_raddr),
        .rdata (rx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_advance)
        begin
            // merge the RAM read data that belongs to this item
            out_res_reg  <= s1_res_reg;
            out_word_reg <= s1_res_reg.rd_word
                            | (s1_res_reg.rx_sel ? {24'd0, rx_rdata} : 32'd0);
            out_byte_reg <= s1_res_reg.send_valid ? tx_rdata : 8'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_word      = out_word_reg;
    assign send_byte      = out_byte_reg;
    assign send_valid     = out_res_reg.send_valid;
    assign dropped        = out_res_reg.dropped;
    assign tx_irq         = out_res_reg.tx_irq;
    assign rx_irq         = out_res_reg.rx_irq;
    assign baud_divisor   = out_res_reg.divisor;
    assign two_stop_bits  = out_res_reg.two_stop;
    assign receiver_on    = out_res_reg.rx_on;
    assign transmitter_on = out_res_reg.tx_on;

    `URFC_ASSERT_NOW(a_tx_fill_bound, 1'b1, status.tx_fill <= FILL_W'(FIFO_DEPTH))
    `URFC_ASSERT_NOW(a_rx_read_nonempty, req.rx_re, status.rx_fill != '0)
    `URFC_ASSERT_NOW(a_send_excl, out_valid && send_valid, read_word == '0 && !dropped)
    `URFC_ASSERT_NOW(a_no_overrun, s1_valid_reg && out_valid_reg && !out_ready, !in_ready)

endmodule

@@ src/urfc_ram.sv @@
// Simple dual-port byte RAM with one write port and a registered read port.
module urfc_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/urfc_ctrl.sv @@
// Register file, FIFO pointers and command decode of the UART register block.
module urfc_ctrl
    import urfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [1:0]   cmd,
    input  logic [2:0]   reg_index,
    input  logic [31:0]  write_word,
    input  logic [3:0]   byte_enables,
    input  logic [7:0]   line_byte,
    output mem_req_t     req,
    output result_t      res,
    output fifo_status_t status
);

    ptr_t        tx_head_reg, tx_head_next, rx_head_reg, rx_head_next;
    fill_t       tx_fill_reg, tx_fill_next, rx_fill_reg, rx_fill_next;
    logic [7:0]  last_tx_reg, last_tx_next;
    logic        tx_en_reg, tx_en_next, stop_sel_reg, stop_sel_next;
    logic [2:0]  tx_mark_reg, tx_mark_next, rx_mark_reg, rx_mark_next;
    logic        rx_en_reg, rx_en_next;
    logic [1:0]  irq_en_reg, irq_en_next;
    logic [15:0] divider_reg, divider_next;

    logic        tx_full, rx_full, tx_irq_cur, rx_irq_cur;
    logic [31:0] rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg  <= '0;
            tx_fill_reg  <= '0;
            rx_head_reg  <= '0;
            rx_fill_reg  <= '0;
            last_tx_reg  <= '0;
            tx_en_reg    <= 1'b0;
            stop_sel_reg <= 1'b0;
            tx_mark_reg  <= '0;
            rx_en_reg    <= 1'b0;
            rx_mark_reg  <= '0;
            irq_en_reg   <= '0;
            divider_reg  <= '0;
        end
        else
        begin
            tx_head_reg  <= tx_head_next;
            tx_fill_reg  <= tx_fill_next;
            rx_head_reg  <= rx_head_next;
            rx_fill_reg  <= rx_fill_next;
            last_tx_reg  <= last_tx_next;
            tx_en_reg    <= tx_en_next;
            stop_sel_reg <= stop_sel_next;
            tx_mark_reg  <= tx_mark_next;
            rx_en_reg    <= rx_en_next;
            rx_mark_reg  <= rx_mark_next;
            irq_en_reg   <= irq_en_next;
            divider_reg  <= divider_next;
        end
    end

    assign tx_full    = (tx_fill_reg == FILL_W'(FIFO_DEPTH));
    assign rx_full    = (rx_fill_reg == FILL_W'(FIFO_DEPTH));
    assign tx_irq_cur = (CMP_W'(tx_fill_reg) < CMP_W'(tx_mark_reg)) && irq_en_reg[0];
    assign rx_irq_cur = (CMP_W'(rx_fill_reg) > CMP_W'(rx_mark_reg)) && irq_en_reg[1];

    always_comb
    begin
        tx_head_next  = tx_head_reg;
        tx_fill_next  = tx_fill_reg;
        rx_head_next  = rx_head_reg;
        rx_fill_next  = rx_fill_reg;
        last_tx_next  = last_tx_reg;
        tx_en_next    = tx_en_reg;
        stop_sel_next = stop_sel_reg;
        tx_mark_next  = tx_mark_reg;
        rx_en_next    = rx_en_reg;
        rx_mark_next  = rx_mark_reg;
        irq_en_next   = irq_en_reg;
        divider_next  = divider_reg;

        rd             = '0;
        res.rx_sel     = 1'b0;
        res.send_valid = 1'b0;
        res.dropped    = 1'b0;

        req.tx_we    = 1'b0;
        req.tx_waddr = wrap_add(tx_head_reg, tx_fill_reg);
        req.tx_wdata = write_word[7:0];
        req.tx_re    = 1'b0;
        req.tx_raddr = tx_head_reg;
        req.rx_we    = 1'b0;
        req.rx_waddr = wrap_add(rx_head_reg, rx_fill_reg);
        req.rx_wdata = line_byte;
        req.rx_re    = 1'b0;
        req.rx_raddr = rx_head_reg;

        if (accept)
        begin
            case (cmd)
                CMD_READ:
                begin
                    case (reg_index)
                        REG_TXDATA: rd = {tx_full, 23'd0, last_tx_reg};
                        REG_RXDATA:
                        begin
                            if (rx_fill_reg == '0)
                            begin
                                rd = 32'h8000_0000;
                            end
                            else
                            begin
                                // head byte arrives from the RAM's registered read port
                                req.rx_re  = 1'b1;
                                res.rx_sel = byte_enables[0];
                                if (byte_enables[0])
                                begin
                                    rx_head_next = wrap_inc(rx_head_reg);
                                    rx_fill_next = rx_fill_reg - FILL_W'(1);
                                end
                            end
                        end
                        REG_TXCTRL: rd = {13'd0, tx_mark_reg, 14'd0, stop_sel_reg, tx_en_reg};
                        REG_RXCTRL: rd = {13'd0, rx_mark_reg, 15'd0, rx_en_reg};
                        REG_IE:     rd = {30'd0, irq_en_reg};
                        REG_IP:     rd = {30'd0, rx_irq_cur, tx_irq_cur};
                        REG_DIV:    rd = {16'd0, divider_reg};
                        default:    rd = '0;
                    endcase
                    rd = rd & be_mask(byte_enables);
                end
                CMD_WRITE:
                begin
                    case (reg_index)
                        REG_TXDATA:
                        begin
                            if (byte_enables[0])
                            begin
                                last_tx_next = write_word[7:0];
                                if (tx_full)
                                begin
                                    res.dropped = 1'b1;
                                end
                                else
                                begin
                                    req.tx_we    = 1'b1;
                                    tx_fill_next = tx_fill_reg + FILL_W'(1);
                                end
                            end
                        end
                        REG_TXCTRL:
                        begin
                            if (byte_enables[0])
                            begin
                                tx_en_next    = write_word[0];
                                stop_sel_next = write_word[1];
                            end
                            if (byte_enables[2])
                            begin
                                tx_mark_next = write_word[18:16];
                            end
                        end
                        REG_RXCTRL:
                        begin
                            if (byte_enables[0])
                            begin
                                rx_en_next = write_word[0];
                            end
                            if (byte_enables[2])
                            begin
                                rx_mark_next = write_word[18:16];
                            end
                        end
                        REG_IE:
                        begin
                            if (byte_enables[0])
                            begin
                                irq_en_next = write_word[1:0];
                            end
                        end
                        REG_DIV:
                        begin
                            if (byte_enables[0])
                            begin
                                divider_next[7:0] = write_word[7:0];
                            end
                            if (byte_enables[1])
                            begin
                                divider_next[15:8] = write_word[15:8];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_LINE_RX:
                begin
                    if (rx_en_reg && !rx_full)
                    begin
                        req.rx_we    = 1'b1;
                        rx_fill_next = rx_fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        res.dropped = 1'b1;
                    end
                end
                CMD_TX_RDY:
                begin
                    if (tx_en_reg && (tx_fill_reg != '0))
                    begin
                        req.tx_re      = 1'b1;
                        res.send_valid = 1'b1;
                        tx_head_next   = wrap_inc(tx_head_reg);
                        tx_fill_next   = tx_fill_reg - FILL_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.rd_word  = rd;
        res.tx_irq   = (CMP_W'(tx_fill_next) < CMP_W'(tx_mark_next)) && irq_en_next[0];
        res.rx_irq   = (CMP_W'(rx_fill_next) > CMP_W'(rx_mark_next)) && irq_en_next[1];
        res.divisor  = divider_next;
        res.two_stop = stop_sel_next;
        res.rx_on    = rx_en_next;
        res.tx_on    = tx_en_next;
    end

    assign status.tx_fill = tx_fill_reg;
    assign status.rx_fill = rx_fill_reg;

endmodule

@@ tb/uart_mirror_pkg.sv @@
// Item and result types plus the shadow model that predicts UART register block results.
package uart_mirror_pkg;
    import urfc_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  reg_index;
        logic [31:0] write_word;
        logic [3:0]  byte_enables;
        logic [7:0]  line_byte;
    } uart_access_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic [7:0]  send_byte;
        logic        send_valid;
        logic        dropped;
        logic        tx_irq;
        logic        rx_irq;
        logic [15:0] baud_divisor;
        logic        two_stop_bits;
        logic        receiver_on;
        logic        transmitter_on;
    } uart_result_t;

    class uart_mirror;
        logic [7:0]        tx_bytes [FIFO_DEPTH];
        logic [7:0]        rx_bytes [FIFO_DEPTH];
        logic [PTR_W-1:0]  tx_head;
        logic [PTR_W-1:0]  rx_head;
        logic [FILL_W-1:0] tx_fill;
        logic [FILL_W-1:0] rx_fill;
        logic [7:0]        last_tx;
        logic              tx_on;
        logic              two_stop;
        logic              rx_on;
        logic [2:0]        tx_mark;
        logic [2:0]        rx_mark;
        logic [1:0]        irq_en;
        logic [15:0]       divider;
        uart_result_t      pending_results [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            for (int i = 0; i < FIFO_DEPTH; i++)
            begin
                tx_bytes[i] = 8'h00;
                rx_bytes[i] = 8'h00;
            end
            tx_head = '0;
            rx_head = '0;
            tx_fill = '0;
            rx_fill = '0;
            last_tx = 8'h00;
            tx_on = 1'b0;
            two_stop = 1'b0;
            rx_on = 1'b0;
            tx_mark = 3'd0;
            rx_mark = 3'd0;
            irq_en = 2'b00;
            divider = 16'h0000;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function logic tx_watermark();
            return (tx_fill < tx_mark) && irq_en[0];
        endfunction

        function logic rx_watermark();
            return (rx_fill > rx_mark) && irq_en[1];
        endfunction

        function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
            return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        function logic [PTR_W-1:0] tail_ptr(logic [PTR_W-1:0] head, logic [FILL_W-1:0] fill);
            int s;
            s = int'(head) + int'(fill);
            if (s >= FIFO_DEPTH)
            begin
                s = s - FIFO_DEPTH;
            end
            return PTR_W'(s);
        endfunction

        // Apply one accepted item to the shadow state and queue the result it causes.
        function void note_access(uart_access_t a);
            uart_result_t r;
            logic [31:0]  rd;
            r = '0;
            rd = '0;
            case (a.cmd)
                CMD_READ:
                begin
                    case (a.reg_index)
                        REG_TXDATA: rd = {(tx_fill >= FIFO_DEPTH), 23'd0, last_tx};
                        REG_RXDATA:
                        begin
                            if (rx_fill == 0)
                            begin
                                rd = 32'h8000_0000;
                            end
                            else
                            begin
                                rd = {24'd0, rx_bytes[rx_head]};
                                // pop only when the data byte is actually read
                                if (a.byte_enables[0])
                                begin
                                    rx_head = next_ptr(rx_head);
                                    rx_fill--;
                                end
                            end
                        end
                        REG_TXCTRL: rd = {13'd0, tx_mark, 14'd0, two_stop, tx_on};
                        REG_RXCTRL: rd = {13'd0, rx_mark, 15'd0, rx_on};
                        REG_IE:     rd = {30'd0, irq_en};
                        REG_IP:     rd = {30'd0, rx_watermark(), tx_watermark()};
                        REG_DIV:    rd = {16'd0, divider};
                        default:    rd = '0;
                    endcase
                    for (int i = 0; i < 4; i++)
                    begin
                        if (!a.byte_enables[i])
                        begin
                            rd[8*i +: 8] = 8'h00;
                        end
                    end
                end
                CMD_WRITE:
                begin
                    case (a.reg_index)
                        REG_TXDATA:
                        begin
                            if (a.byte_enables[0])
                            begin
                                last_tx = a.write_word[7:0];
                                if (tx_fill < FIFO_DEPTH)
                                begin
                                    tx_bytes[tail_ptr(tx_head, tx_fill)] = last_tx;
                                    tx_fill++;
                                end
                                else
                                begin
                                    r.dropped = 1'b1;
                                end
                            end
                        end
                        REG_TXCTRL:
                        begin
                            if (a.byte_enables[0])
                            begin
                                tx_on = a.write_word[0];
                                two_stop = a.write_word[1];
                            end
                            if (a.byte_enables[2])
                            begin
                                tx_mark = a.write_word[18:16];
                            end
                        end
                        REG_RXCTRL:
                        begin
                            if (a.byte_enables[0])
                            begin
                                rx_on = a.write_word[0];
                            end
                            if (a.byte_enables[2])
                            begin
                                rx_mark = a.write_word[18:16];
                            end
                        end
                        REG_IE:
                        begin
                            if (a.byte_enables[0])
                            begin
                                irq_en = a.write_word[1:0];
                            end
                        end
                        REG_DIV:
                        begin
                            if (a.byte_enables[0])
                            begin
                                divider[7:0] = a.write_word[7:0];
                            end
                            if (a.byte_enables[1])
                            begin
                                divider[15:8] = a.write_word[15:8];
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_LINE_RX:
                begin
                    if (rx_on && rx_fill < FIFO_DEPTH)
                    begin
                        rx_bytes[tail_ptr(rx_head, rx_fill)] = a.line_byte;
                        rx_fill++;
                    end
                    else
                    begin
                        r.dropped = 1'b1;
                    end
                end
                default:
                begin
                    if (tx_on && tx_fill != 0)
                    begin
                        r.send_byte = tx_bytes[tx_head];
                        r.send_valid = 1'b1;
                        tx_head = next_ptr(tx_head);
                        tx_fill--;
                    end
                end
            endcase
            r.read_word = rd;
            r.tx_irq = tx_watermark();
            r.rx_irq = rx_watermark();
            r.baud_divisor = divider;
            r.two_stop_bits = two_stop;
            r.receiver_on = rx_on;
            r.transmitter_on = tx_on;
            pending_results.push_back(r);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, what, exp_v, act_v);
            end
        endfunction

        function void check_result(uart_result_t act);
            uart_result_t exp_r;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report("unexpected result, read_word", 32'd0, act.read_word);
                return;
            end
            exp_r = pending_results.pop_front();
            if (exp_r.read_word !== act.read_word)
                report("read_word", exp_r.read_word, act.read_word);
            if (exp_r.send_byte !== act.send_byte)
                report("send_byte", exp_r.send_byte, act.send_byte);
            if (exp_r.send_valid !== act.send_valid)
                report("send_valid", exp_r.send_valid, act.send_valid);
            if (exp_r.dropped !== act.dropped)
                report("dropped", exp_r.dropped, act.dropped);
            if (exp_r.tx_irq !== act.tx_irq)
                report("tx_irq", exp_r.tx_irq, act.tx_irq);
            if (exp_r.rx_irq !== act.rx_irq)
                report("rx_irq", exp_r.rx_irq, act.rx_irq);
            if (exp_r.baud_divisor !== act.baud_divisor)
                report("baud_divisor", exp_r.baud_divisor, act.baud_divisor);
            if (exp_r.two_stop_bits !== act.two_stop_bits)
                report("two_stop_bits", exp_r.two_stop_bits, act.two_stop_bits);
            if (exp_r.receiver_on !== act.receiver_on)
                report("receiver_on", exp_r.receiver_on, act.receiver_on);
            if (exp_r.transmitter_on !== act.transmitter_on)
                report("transmitter_on", exp_r.transmitter_on, act.transmitter_on);
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for the UART register block with transmit and receive FIFOs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urfc_pkg::*;
    import uart_mirror_pkg::*;

    localparam int PERIOD       = 4;
    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [2:0]  reg_index;
    logic [31:0] write_word;
    logic [3:0]  byte_enables;
    logic [7:0]  line_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_word;
    logic [7:0]  send_byte;
    logic        send_valid;
    logic        dropped;
    logic        tx_irq;
    logic        rx_irq;
    logic [15:0] baud_divisor;
    logic        two_stop_bits;
    logic        receiver_on;
    logic        transmitter_on;

    uart_mirror  mirror;
    bit          in_quiet;
    int unsigned cycle_count;

    uart_register_fifo_controller_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .reg_index      (reg_index),
        .write_word     (write_word),
        .byte_enables   (byte_enables),
        .line_byte      (line_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_word      (read_word),
        .send_byte      (send_byte),
        .send_valid     (send_valid),
        .dropped        (dropped),
        .tx_irq         (tx_irq),
        .rx_irq         (rx_irq),
        .baud_divisor   (baud_divisor),
        .two_stop_bits  (two_stop_bits),
        .receiver_on    (receiver_on),
        .transmitter_on (transmitter_on)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge; note the item before checking the result.
    always @(posedge clk)
    begin
        uart_access_t acc;
        uart_result_t res;
        if (rst_n && in_valid && in_ready)
        begin
            acc.cmd = cmd;
            acc.reg_index = reg_index;
            acc.write_word = write_word;
            acc.byte_enables = byte_enables;
            acc.line_byte = line_byte;
            mirror.note_access(acc);
        end
        if (rst_n && out_valid && out_ready)
        begin
            res.read_word = read_word;
            res.send_byte = send_byte;
            res.send_valid = send_valid;
            res.dropped = dropped;
            res.tx_irq = tx_irq;
            res.rx_irq = rx_irq;
            res.baud_divisor = baud_divisor;
            res.two_stop_bits = two_stop_bits;
            res.receiver_on = receiver_on;
            res.transmitter_on = transmitter_on;
            mirror.check_result(res);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_access(input logic [1:0] c, input logic [2:0] r,
                               input logic [31:0] w, input logic [3:0] b,
                               input logic [7:0] l);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        reg_index <= r;
        write_word <= w;
        byte_enables <= b;
        line_byte <= l;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Mode 0 fills both FIFOs, 1 drains them, 2 rewrites control registers and reads registers, 3 is noise.
    function automatic uart_access_t random_access(int mode);
        uart_access_t a;
        int pick;
        a.write_word = $urandom;
        a.line_byte = 8'($urandom_range(0, 255));
        a.byte_enables = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
        a.reg_index = 3'($urandom_range(0, 7));
        a.cmd = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        case (mode)
            0:
            begin
                if (pick < 4)
                begin
                    a.cmd = CMD_WRITE;
                    a.reg_index = REG_TXDATA;
                end
                else if (pick < 8)
                begin
                    a.cmd = CMD_LINE_RX;
                end
            end
            1:
            begin
                if (pick < 4)
                begin
                    a.cmd = CMD_TX_RDY;
                end
                else if (pick < 8)
                begin
                    a.cmd = CMD_READ;
                    a.reg_index = REG_RXDATA;
                end
            end
            2:
            begin
                if (pick < 6)
                begin
                    a.cmd = CMD_WRITE;
                    case ($urandom_range(0, 3))
                        0:       a.reg_index = REG_TXCTRL;
                        1:       a.reg_index = REG_RXCTRL;
                        2:       a.reg_index = REG_IE;
                        default: a.reg_index = REG_DIV;
                    endcase
                    // keep enables mostly on so the FIFOs keep moving
                    a.write_word[0] = ($urandom_range(0, 4) != 0);
                end
                else
                begin
                    a.cmd = CMD_READ;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    initial
    begin : out_side
        int gap;
        int stretch;
        bit out_quiet;
        stretch = 0;
        out_quiet = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (stretch == 0)
            begin
                out_quiet = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            gap = out_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        uart_access_t a;
        int mode;
        int burst_len;
        int sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cmd = CMD_READ;
        reg_index = REG_TXDATA;
        write_word = 32'd0;
        byte_enables = 4'h0;
        line_byte = 8'h00;
        in_quiet = 1'b0;
        cycle_count = 0;
        mirror = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, empty reads and ignored writes
        send_access(CMD_READ, REG_TXDATA, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_RXDATA, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_TXCTRL, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_NONE, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_IP, 32'd0, 4'hF, 8'h00);
        send_access(CMD_WRITE, REG_TXDATA, 32'hFFFF_FFFF, 4'h0, 8'h00);
        send_access(CMD_WRITE, REG_IP, 32'hFFFF_FFFF, 4'hF, 8'h00);
        send_access(CMD_WRITE, REG_NONE, 32'hFFFF_FFFF, 4'hF, 8'h00);
        // enable everything with the widest marks
        send_access(CMD_WRITE, REG_TXCTRL, 32'h0007_0003, 4'hF, 8'h00);
        send_access(CMD_WRITE, REG_RXCTRL, 32'hFFFF_FFFF, 4'hF, 8'h00);
        send_access(CMD_WRITE, REG_IE, 32'h0000_0003, 4'h1, 8'h00);
        send_access(CMD_WRITE, REG_DIV, 32'hFFFF_FFFF, 4'h3, 8'h00);
        send_access(CMD_WRITE, REG_DIV, 32'h0000_0000, 4'h2, 8'h00);
        send_access(CMD_READ, REG_IP, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_RXCTRL, 32'd0, 4'hF, 8'h00);
        // push two bytes, pop them, pop once more on empty
        send_access(CMD_WRITE, REG_TXDATA, 32'h0000_00FF, 4'h1, 8'h00);
        send_access(CMD_WRITE, REG_TXDATA, 32'hFFFF_FF00, 4'hF, 8'h00);
        send_access(CMD_TX_RDY, REG_NONE, 32'd0, 4'h0, 8'h00);
        send_access(CMD_TX_RDY, REG_NONE, 32'd0, 4'h0, 8'h00);
        send_access(CMD_TX_RDY, REG_NONE, 32'd0, 4'h0, 8'h00);
        // receive side: peek without popping, pop both bytes, read when empty
        send_access(CMD_LINE_RX, REG_NONE, 32'd0, 4'h0, 8'hFF);
        send_access(CMD_LINE_RX, REG_NONE, 32'd0, 4'h0, 8'h00);
        send_access(CMD_READ, REG_RXDATA, 32'd0, 4'hE, 8'h00);
        send_access(CMD_READ, REG_RXDATA, 32'd0, 4'hF, 8'h00);
        send_access(CMD_READ, REG_RXDATA, 32'd0, 4'h1, 8'h00);
        send_access(CMD_READ, REG_RXDATA, 32'd0, 4'hF, 8'h00);
        // receiver off drops the line byte
        send_access(CMD_WRITE, REG_RXCTRL, 32'h0000_0000, 4'h1, 8'h00);
        send_access(CMD_LINE_RX, REG_NONE, 32'd0, 4'h0, 8'hA5);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            burst_len = $urandom_range(8, 40);
            in_quiet = ($urandom_range(0, 3) == 0);
            repeat (burst_len)
            begin
                a = random_access(mode);
                send_access(a.cmd, a.reg_index, a.write_word, a.byte_enables, a.line_byte);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
